[rtl/sha1_pkg.sv]
package sha1_pkg;

  localparam int NUM_WORDS = 5;
  localparam int WORD_W    = 32;
  localparam int SCHED_LEN = 16;

  // item queue between the front end and the core
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [WORD_W-1:0] H_INIT [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [6:0] LAST_RND  = 7'd79;
  localparam logic [2:0] LAST_IDX  = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } item_t;

  typedef struct packed {
    logic                              err;
    logic [NUM_WORDS-1:0][WORD_W-1:0] words;
  } digest_t;

  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_PAD80 = 7'b0000010,
    ST_PADZ  = 7'b0000100,
    ST_PADL  = 7'b0001000,
    ST_ROUND = 7'b0010000,
    ST_ADD   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

endpackage

[rtl/sha1_front.sv]
module sha1_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [7:0]        in_data_byte,
  input  logic              in_has_byte,
  input  logic              in_end_of_message,
  output logic              full,
  output sha1_pkg::item_t   item_o,
  output logic              item_valid_o,
  input  logic              item_ready_i
);

  sha1_pkg::item_t          q_r [sha1_pkg::QDEPTH];
  logic [sha1_pkg::QAW-1:0] wr_r, rd_r;
  logic [sha1_pkg::QAW:0]   cnt_r;
  logic                     wr_en, rd_en, acc;

  assign full         = (cnt_r == (sha1_pkg::QAW+1)'(sha1_pkg::QDEPTH));
  assign acc          = push & ~full;
  // items that carry neither a byte nor an end mark change nothing: drop them here
  assign wr_en        = acc & (in_has_byte | in_end_of_message);
  assign item_valid_o = (cnt_r != '0);
  assign rd_en        = item_valid_o & item_ready_i;
  assign item_o       = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wr_r <= wr_r + 1'b1;
      if (rd_en) rd_r <= rd_r + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_r].data     <= in_data_byte;
      q_r[wr_r].has_byte <= in_has_byte;
      q_r[wr_r].eom      <= in_end_of_message;
    end
  end

endmodule

[rtl/sha1_core.sv]
module sha1_core (
  input  logic              clk,
  input  logic              rst_n,
  input  sha1_pkg::item_t   item_i,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  output sha1_pkg::digest_t dig_o,
  output logic              dig_valid_o,
  input  logic              dig_ready_i
);

  sha1_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [5:0]       pos_r, pos_nxt;
  logic [63:0]      cnt_r, cnt_nxt, cnt_sum;
  logic             ovf_r, ovf_nxt, ovf_item;
  logic [6:0]       t_r, t_nxt;
  logic [31:0]      h_r [sha1_pkg::NUM_WORDS];
  logic [31:0]      h_nxt [sha1_pkg::NUM_WORDS];

  logic [23:0]      acc_r, acc_nxt;
  logic [31:0]      line_r [sha1_pkg::SCHED_LEN];
  logic [31:0]      line_nxt [sha1_pkg::SCHED_LEN];
  logic [31:0]      a_r, b_r, c_r, d_r, e_r;
  logic [31:0]      a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;

  logic             byte_we, shift_en, take;
  logic [7:0]       byte_val;
  logic [31:0]      shift_in, w, f, k;
  sha1_pkg::state_t end_tgt;

  assign cnt_sum      = cnt_r + 64'd8;
  assign item_ready_o = (state_r == sha1_pkg::ST_LOAD);
  assign dig_valid_o  = (state_r == sha1_pkg::ST_DONE);

  always_comb begin
    dig_o.err = ovf_r;
    for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) begin
      dig_o.words[i] = ovf_r ? '0 : h_r[i];
    end
  end

  // message schedule: from round 16 on, line_r[0] is W[t-16] and line_r[15] is W[t-1]; before that, line_r[0] is W[t]
  always_comb begin
    if (t_r < 7'd16) begin
      w = line_r[0];
    end else begin
      w = line_r[13] ^ line_r[8] ^ line_r[2] ^ line_r[0];
      w = {w[30:0], w[31]};
    end
    if (t_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = sha1_pkg::K0;
    end else if (t_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = sha1_pkg::K1;
    end else if (t_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = sha1_pkg::K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = sha1_pkg::K3;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    t_nxt     = t_r;
    acc_nxt   = acc_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    e_nxt     = e_r;
    for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) h_nxt[i] = h_r[i];
    byte_we   = 1'b0;
    byte_val  = '0;
    shift_en  = 1'b0;
    shift_in  = w;
    take      = 1'b0;
    ovf_item  = ovf_r;
    end_tgt   = sha1_pkg::ST_PAD80;

    case (state_r)
      sha1_pkg::ST_LOAD: begin
        if (item_valid_i) begin
          take = item_i.has_byte & ~ovf_r;
          if (take) begin
            byte_we  = 1'b1;
            byte_val = item_i.data;
            cnt_nxt  = cnt_sum;
            if (cnt_sum == '0) ovf_item = 1'b1;
          end
          ovf_nxt = ovf_item;
          end_tgt = ovf_item ? sha1_pkg::ST_DONE : sha1_pkg::ST_PAD80;
          if (take && pos_r == sha1_pkg::LAST_POS) begin
            state_nxt = sha1_pkg::ST_ROUND;
            ret_nxt   = item_i.eom ? end_tgt : sha1_pkg::ST_LOAD;
          end else if (item_i.eom) begin
            state_nxt = end_tgt;
          end
        end
      end
      sha1_pkg::ST_PAD80: begin
        byte_we   = 1'b1;
        byte_val  = sha1_pkg::PAD_BYTE;
        state_nxt = sha1_pkg::ST_PADZ;
        if (pos_r == sha1_pkg::LAST_POS) begin
          state_nxt = sha1_pkg::ST_ROUND;
          ret_nxt   = sha1_pkg::ST_PADZ;
        end
      end
      sha1_pkg::ST_PADZ: begin
        // zeros up to the length field; past it, zeros to the block end first
        if (pos_r == sha1_pkg::LEN_POS) begin
          state_nxt = sha1_pkg::ST_PADL;
        end else begin
          byte_we = 1'b1;
          if (pos_r == sha1_pkg::LAST_POS) begin
            state_nxt = sha1_pkg::ST_ROUND;
            ret_nxt   = sha1_pkg::ST_PADZ;
          end
        end
      end
      sha1_pkg::ST_PADL: begin
        byte_we  = 1'b1;
        byte_val = cnt_r[{~pos_r[2:0], 3'b000} +: 8];
        if (pos_r == sha1_pkg::LAST_POS) begin
          state_nxt = sha1_pkg::ST_ROUND;
          ret_nxt   = sha1_pkg::ST_DONE;
        end
      end
      sha1_pkg::ST_ROUND: begin
        shift_en = 1'b1;
        a_nxt    = {a_r[26:0], a_r[31:27]} + f + e_r + w + k;
        b_nxt    = a_r;
        c_nxt    = {b_r[1:0], b_r[31:2]};
        d_nxt    = c_r;
        e_nxt    = d_r;
        t_nxt    = t_r + 1'b1;
        if (t_r == sha1_pkg::LAST_RND) begin
          t_nxt     = '0;
          state_nxt = sha1_pkg::ST_ADD;
        end
      end
      sha1_pkg::ST_ADD: begin
        h_nxt[0]  = h_r[0] + a_r;
        h_nxt[1]  = h_r[1] + b_r;
        h_nxt[2]  = h_r[2] + c_r;
        h_nxt[3]  = h_r[3] + d_r;
        h_nxt[4]  = h_r[4] + e_r;
        state_nxt = ret_r;
      end
      sha1_pkg::ST_DONE: begin
        if (dig_ready_i) begin
          for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) h_nxt[i] = sha1_pkg::H_INIT[i];
          pos_nxt   = '0;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = sha1_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = sha1_pkg::ST_LOAD;
      end
    endcase

    // byte packer, shared by message and padding bytes
    if (byte_we) begin
      pos_nxt = pos_r + 1'b1;
      if (pos_r[1:0] == 2'b11) begin
        shift_en = 1'b1;
        shift_in = {acc_r, byte_val};
      end else begin
        acc_nxt = {acc_r[15:0], byte_val};
      end
      if (pos_r == sha1_pkg::LAST_POS) begin
        a_nxt = h_r[0];
        b_nxt = h_r[1];
        c_nxt = h_r[2];
        d_nxt = h_r[3];
        e_nxt = h_r[4];
      end
    end

    for (int i = 0; i < sha1_pkg::SCHED_LEN; i++) line_nxt[i] = line_r[i];
    if (shift_en) begin
      for (int i = 0; i < sha1_pkg::SCHED_LEN - 1; i++) line_nxt[i] = line_r[i+1];
      line_nxt[sha1_pkg::SCHED_LEN-1] = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1_pkg::ST_LOAD;
      ret_r   <= sha1_pkg::ST_LOAD;
      pos_r   <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      t_r     <= '0;
      for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) h_r[i] <= sha1_pkg::H_INIT[i];
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      t_r     <= t_nxt;
      for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) h_r[i] <= h_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
    for (int i = 0; i < sha1_pkg::SCHED_LEN; i++) line_r[i] <= line_nxt[i];
  end

endmodule

[rtl/sha1_out.sv]
module sha1_out (
  input  logic              clk,
  input  logic              rst_n,
  input  sha1_pkg::digest_t dig_i,
  input  logic              dig_valid_i,
  output logic              dig_ready_o,
  output logic              empty,
  input  logic              pop,
  output logic [31:0]       out_digest_word,
  output logic [2:0]        out_word_index,
  output logic              out_last_word,
  output logic              out_length_error
);

  logic                                                 hold_r;
  logic [2:0]                                           idx_r;
  logic [sha1_pkg::NUM_WORDS-1:0][sha1_pkg::WORD_W-1:0] words_r;
  logic                                                 err_r;
  logic                                                 last, done;

  assign last             = (idx_r == sha1_pkg::LAST_IDX);
  assign done             = hold_r & pop & last;
  // a new digest may load in the cycle the last word leaves
  assign dig_ready_o      = ~hold_r | done;
  assign empty            = ~hold_r;
  assign out_digest_word  = words_r[idx_r];
  assign out_word_index   = idx_r;
  assign out_last_word    = last;
  assign out_length_error = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      idx_r  <= '0;
    end else if (dig_valid_i && dig_ready_o) begin
      hold_r <= 1'b1;
      idx_r  <= '0;
    end else if (done) begin
      hold_r <= 1'b0;
      idx_r  <= '0;
    end else if (hold_r && pop) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dig_valid_i && dig_ready_o) begin
      words_r <= dig_i.words;
      err_r   <= dig_i.err;
    end
  end

endmodule

[rtl/sha1_hash.sv]
// SHA-1 over a byte stream. Each input transaction may carry one message byte and
// may end the message; transactions with neither are taken and ignored. Bytes pass
// through a four-entry queue into the core, which takes at most one byte per cycle,
// so a full 64-byte block costs the loading of its bytes plus the 80 rounds, one per
// cycle, and the chaining add. At the end mark the core writes padding and length
// at one byte per cycle, pausing once before the length field, with one compression
// or, when the length does not fit in the current block, two compressions. It then
// hands the digest to the output stage, which presents five transactions, most
// significant word first; the output stage takes a new digest only once the last
// word of the previous one has left, and the core starts on the next message as soon
// as its digest is taken. Once the queue has filled, input stalls while a block
// compresses, while padding runs and while the core waits on the output stage. A
// 64-bit bit count overflow drops the rest of the message and flags length_error
// with zero words.
module sha1_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        out_length_error
);

  sha1_pkg::item_t   item;
  logic              item_valid, item_ready;
  sha1_pkg::digest_t dig;
  logic              dig_valid, dig_ready;

  sha1_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .full              (full),
    .item_o            (item),
    .item_valid_o      (item_valid),
    .item_ready_i      (item_ready)
  );

  sha1_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .dig_o        (dig),
    .dig_valid_o  (dig_valid),
    .dig_ready_i  (dig_ready)
  );

  sha1_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .dig_i            (dig),
    .dig_valid_i      (dig_valid),
    .dig_ready_o      (dig_ready),
    .empty            (empty),
    .pop              (pop),
    .out_digest_word  (out_digest_word),
    .out_word_index   (out_word_index),
    .out_last_word    (out_last_word),
    .out_length_error (out_length_error)
  );

endmodule
